### design/igzi_pkg.sv
package igzi_pkg;

	localparam int CW = 33;
	localparam logic [3:0] MAX_LEVEL = 4'd10;
	localparam int FACES = 20;
	localparam logic signed [31:0] VA = 32'sd913379351;
	localparam logic signed [31:0] VB = 32'sd564499483;

	localparam logic [6:0] PLANE_LAST = 7'd10;
	localparam logic [6:0] SQ_LAST = 7'd3;
	localparam logic [6:0] ROOT_LAST = 7'd32;
	localparam logic [6:0] DIV_LAST = 7'd64;

	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_BASE  = 4'd2;
	localparam logic [3:0] OP_MISS  = 4'd3;
	localparam logic [3:0] OP_PLANE = 4'd4;
	localparam logic [3:0] OP_SUM   = 4'd5;
	localparam logic [3:0] OP_SQ    = 4'd6;
	localparam logic [3:0] OP_ROOT  = 4'd7;
	localparam logic [3:0] OP_DIV   = 4'd8;
	localparam logic [3:0] OP_WR    = 4'd9;
	localparam logic [3:0] OP_CHILD = 4'd10;

	// vector pairs for plane normals
	localparam logic [2:0] PAIR_C01 = 3'd0;
	localparam logic [2:0] PAIR_C12 = 3'd1;
	localparam logic [2:0] PAIR_C20 = 3'd2;
	localparam logic [2:0] PAIR_E12 = 3'd3;
	localparam logic [2:0] PAIR_E20 = 3'd4;
	localparam logic [2:0] PAIR_E01 = 3'd5;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef struct packed {
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [3:0]         depth_level;
	} zone_req_t;

	typedef struct packed {
		logic [24:0] zone;
		logic        found;
	} zone_res_t;

	typedef struct packed {
		logic [3:0] op;
		logic [6:0] step;
		logic [2:0] pair;
		logic [1:0] mid;
		logic [1:0] child;
		logic [4:0] face;
	} dp_cmd_t;

	typedef struct packed {
		logic       ge;
		logic       le;
		logic [3:0] level;
	} dp_status_t;

	localparam logic signed [31:0] VERT [12][3] = '{
		'{ VA, -VB, 32'sd0}, '{ VA,  VB, 32'sd0},
		'{-VA,  VB, 32'sd0}, '{-VA, -VB, 32'sd0},
		'{32'sd0,  VA, -VB}, '{32'sd0,  VA,  VB},
		'{32'sd0, -VA,  VB}, '{32'sd0, -VA, -VB},
		'{-VB, 32'sd0,  VA}, '{ VB, 32'sd0,  VA},
		'{ VB, 32'sd0, -VA}, '{-VB, 32'sd0, -VA}
	};

	localparam logic [3:0] FACE_VERT [FACES][3] = '{
		'{4'd1, 4'd0, 4'd10}, '{4'd0, 4'd1, 4'd9},  '{4'd0, 4'd9, 4'd6},
		'{4'd9, 4'd8, 4'd6},  '{4'd0, 4'd7, 4'd10}, '{4'd6, 4'd7, 4'd0},
		'{4'd7, 4'd6, 4'd3},  '{4'd6, 4'd8, 4'd3},  '{4'd11, 4'd10, 4'd7},
		'{4'd7, 4'd3, 4'd11}, '{4'd3, 4'd2, 4'd11}, '{4'd2, 4'd3, 4'd8},
		'{4'd10, 4'd11, 4'd4}, '{4'd2, 4'd4, 4'd11}, '{4'd5, 4'd4, 4'd2},
		'{4'd2, 4'd8, 4'd5},  '{4'd4, 4'd1, 4'd10}, '{4'd4, 4'd5, 4'd1},
		'{4'd5, 4'd9, 4'd1},  '{4'd8, 4'd9, 4'd5}
	};

	function automatic vec_t base_vec(input logic [4:0] face, input logic [1:0] corner);
		logic [3:0] k;
		vec_t v;
		k = FACE_VERT[face][corner];
		v.x = CW'(VERT[k][0]);
		v.y = CW'(VERT[k][1]);
		v.z = CW'(VERT[k][2]);
		return v;
	endfunction

endpackage

### design/icosahedral_grid_zone_index_unit.sv
// channel   signals                       transaction when
// request   start, busy, request          start & !busy
// result    done, result                  done (one cycle, no back pressure)
// config    cfg_valid, cfg_ready, cfg_data cfg_valid & cfg_ready
//
// from the accepting edge an item runs a face search over the 20 faces (each a load step
// and up to three plane tests), then per level three midpoints (each a sum, square,
// root, divide and write) and one to three plane tests, then the result strobe
// all products share one multiplier; busy stays high until the result strobe
// reset clears the controller and sets edge_tolerance to 1
// the receiver cannot stall; cfg_ready is always high
module icosahedral_grid_zone_index_unit
	import igzi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  zone_req_t  request,
	output logic       done,
	output zone_res_t  result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] cfg_data
);

	dp_cmd_t cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	igzi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	igzi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.status    (status),
		.result    (result)
	);

endmodule

### design/igzi_datapath.sv
module igzi_datapath
	import igzi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  zone_req_t  request,
	input  logic       cfg_valid,
	input  logic [9:0] cfg_data,
	output dp_status_t status,
	output zone_res_t  result
);

	logic [9:0] tol_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [3:0] level_q;
	vec_t c0_q, c1_q, c2_q, e0_q, e1_q, e2_q;
	logic signed [33:0] n0_q, n1_q, n2_q;
	logic signed [63:0] acc_q, prod_q;
	logic signed [33:0] sum_q [3];
	logic [63:0] sq_q;
	logic [63:0] root_rem_q, root_res_q, root_bit_q;
	logic [32:0] rem_q [3];
	logic [63:0] quo_q [3];
	logic [24:0] zone_q;
	logic found_q;

	vec_t va, vb;
	logic signed [34:0] mul_a, mul_b;
	logic signed [69:0] mul_full;
	logic signed [63:0] diff, rnd;
	logic signed [63:0] slack;
	logic [32:0] len;
	logic [63:0] root_try;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 10'd1;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	always_comb begin
		unique case (cmd.pair)
			PAIR_C01: begin va = c0_q; vb = c1_q; end
			PAIR_C12: begin va = c1_q; vb = c2_q; end
			PAIR_C20: begin va = c2_q; vb = c0_q; end
			PAIR_E12: begin va = e1_q; vb = e2_q; end
			PAIR_E20: begin va = e2_q; vb = e0_q; end
			PAIR_E01: begin va = e0_q; vb = e1_q; end
			default:  begin va = c0_q; vb = c1_q; end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.op == OP_PLANE) begin
			unique case (cmd.step)
				7'd0: begin mul_a = 35'(va.y); mul_b = 35'(vb.z); end
				7'd1: begin mul_a = 35'(va.z); mul_b = 35'(vb.y); end
				7'd2: begin mul_a = 35'(va.z); mul_b = 35'(vb.x); end
				7'd3: begin mul_a = 35'(va.x); mul_b = 35'(vb.z); end
				7'd4: begin mul_a = 35'(va.x); mul_b = 35'(vb.y); end
				7'd5: begin mul_a = 35'(va.y); mul_b = 35'(vb.x); end
				7'd6: begin mul_a = 35'(n0_q); mul_b = 35'(px_q); end
				7'd7: begin mul_a = 35'(n1_q); mul_b = 35'(py_q); end
				7'd8: begin mul_a = 35'(n2_q); mul_b = 35'(pz_q); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (cmd.op == OP_SQ) begin
			unique case (cmd.step)
				7'd0: begin mul_a = 35'(sum_q[0]); mul_b = 35'(sum_q[0]); end
				7'd1: begin mul_a = 35'(sum_q[1]); mul_b = 35'(sum_q[1]); end
				7'd2: begin mul_a = 35'(sum_q[2]); mul_b = 35'(sum_q[2]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	assign mul_full = mul_a * mul_b;
	// round half up to q30
	assign diff = acc_q - prod_q;
	assign rnd = diff + 64'sd536870912;
	assign slack = signed'({24'd0, tol_q, 30'd0});
	assign len = root_res_q[32:0];
	assign root_try = root_res_q + root_bit_q;

	always_ff @(posedge clk) begin
		prod_q <= mul_full[63:0];
		unique case (cmd.op)
			OP_LOAD: begin
				px_q <= request.dir_x;
				py_q <= request.dir_y;
				pz_q <= request.dir_z;
				level_q <= (request.depth_level > MAX_LEVEL) ? MAX_LEVEL : request.depth_level;
			end
			OP_BASE: begin
				c0_q <= base_vec(cmd.face, 2'd0);
				c1_q <= base_vec(cmd.face, 2'd1);
				c2_q <= base_vec(cmd.face, 2'd2);
				zone_q <= 25'(cmd.face);
				found_q <= 1'b1;
			end
			OP_MISS: begin
				zone_q <= '0;
				found_q <= 1'b0;
			end
			OP_PLANE: begin
				unique case (cmd.step)
					7'd1, 7'd3, 7'd5, 7'd7: acc_q <= prod_q;
					7'd2: n0_q <= rnd[63:30];
					7'd4: n1_q <= rnd[63:30];
					7'd6: n2_q <= rnd[63:30];
					7'd8, 7'd9: acc_q <= acc_q + prod_q;
					default: ;
				endcase
			end
			OP_SUM: begin
				unique case (cmd.mid)
					2'd0: begin
						sum_q[0] <= 34'(c1_q.x) + 34'(c2_q.x);
						sum_q[1] <= 34'(c1_q.y) + 34'(c2_q.y);
						sum_q[2] <= 34'(c1_q.z) + 34'(c2_q.z);
					end
					2'd1: begin
						sum_q[0] <= 34'(c2_q.x) + 34'(c0_q.x);
						sum_q[1] <= 34'(c2_q.y) + 34'(c0_q.y);
						sum_q[2] <= 34'(c2_q.z) + 34'(c0_q.z);
					end
					default: begin
						sum_q[0] <= 34'(c0_q.x) + 34'(c1_q.x);
						sum_q[1] <= 34'(c0_q.y) + 34'(c1_q.y);
						sum_q[2] <= 34'(c0_q.z) + 34'(c1_q.z);
					end
				endcase
			end
			OP_SQ: begin
				if (cmd.step == 7'd1) begin
					sq_q <= prod_q;
				end else if (cmd.step != 7'd0) begin
					sq_q <= sq_q + prod_q;
				end
			end
			OP_ROOT: begin
				if (cmd.step == 7'd0) begin
					root_rem_q <= sq_q;
					root_res_q <= '0;
					root_bit_q <= 64'd1 << 62;
				end else begin
					if (root_rem_q >= root_try) begin
						root_rem_q <= root_rem_q - root_try;
						root_res_q <= (root_res_q >> 1) + root_bit_q;
					end else begin
						root_res_q <= root_res_q >> 1;
					end
					root_bit_q <= root_bit_q >> 2;
				end
			end
			OP_DIV: begin
				for (int k = 0; k < 3; k++) begin
					logic [33:0] mag;
					logic [33:0] trial;
					mag = sum_q[k][33] ? 34'(-sum_q[k]) : 34'(sum_q[k]);
					trial = {rem_q[k], quo_q[k][63]};
					if (cmd.step == 7'd0) begin
						rem_q[k] <= '0;
						quo_q[k] <= (64'(mag) << 30) + 64'(len >> 1);
					end else if (trial >= {1'b0, len}) begin
						rem_q[k] <= 33'(trial - {1'b0, len});
						quo_q[k] <= {quo_q[k][62:0], 1'b1};
					end else begin
						rem_q[k] <= trial[32:0];
						quo_q[k] <= {quo_q[k][62:0], 1'b0};
					end
				end
			end
			OP_WR: begin
				vec_t m;
				logic [63:0] qv [3];
				for (int k = 0; k < 3; k++) begin
					qv[k] = sum_q[k][33] ? -quo_q[k] : quo_q[k];
				end
				if (len == '0) begin
					m.x = sum_q[0][32:0];
					m.y = sum_q[1][32:0];
					m.z = sum_q[2][32:0];
				end else begin
					m.x = qv[0][32:0];
					m.y = qv[1][32:0];
					m.z = qv[2][32:0];
				end
				unique case (cmd.mid)
					2'd0: e0_q <= m;
					2'd1: e1_q <= m;
					default: e2_q <= m;
				endcase
			end
			OP_CHILD: begin
				zone_q <= {zone_q[22:0], cmd.child};
				unique case (cmd.child)
					2'd0: begin c1_q <= e2_q; c2_q <= e1_q; end
					2'd1: begin c0_q <= e2_q; c2_q <= e0_q; end
					2'd2: begin c0_q <= e1_q; c1_q <= e0_q; end
					default: begin c0_q <= e0_q; c1_q <= e1_q; c2_q <= e2_q; end
				endcase
			end
			default: ;
		endcase
	end

	assign status.ge = (acc_q >= -slack);
	assign status.le = (acc_q <= slack);
	assign status.level = level_q;
	assign result.zone = zone_q;
	assign result.found = found_q;

endmodule

### design/igzi_ctrl.sv
module igzi_ctrl
	import igzi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BASE  = 4'd1;
	localparam logic [3:0] S_FACE  = 4'd2;
	localparam logic [3:0] S_SUM   = 4'd3;
	localparam logic [3:0] S_SQ    = 4'd4;
	localparam logic [3:0] S_ROOT  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_WR    = 4'd7;
	localparam logic [3:0] S_CTEST = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0] state_q, state_d;
	logic [6:0] step_q, step_d;
	logic [4:0] face_q, face_d;
	logic [1:0] edge_q, edge_d;
	logic [1:0] mid_q, mid_d;
	logic [3:0] lev_q, lev_d;
	logic more_levels;

	assign more_levels = ({1'b0, lev_q} + 5'd1) < {1'b0, status.level};

	always_comb begin
		state_d = state_q;
		step_d = step_q + 7'd1;
		face_d = face_q;
		edge_d = edge_q;
		mid_d = mid_q;
		lev_d = lev_q;
		cmd = '0;
		cmd.op = OP_NONE;
		cmd.step = step_q;
		cmd.face = face_q;
		cmd.mid = mid_q;
		cmd.pair = {1'b0, edge_q};
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_LOAD;
					face_d = '0;
					state_d = S_BASE;
				end
			end
			S_BASE: begin
				cmd.op = OP_BASE;
				edge_d = '0;
				step_d = '0;
				state_d = S_FACE;
			end
			S_FACE: begin
				cmd.op = OP_PLANE;
				if (step_q == PLANE_LAST) begin
					step_d = '0;
					if (!status.ge) begin
						if (face_q == 5'(FACES - 1)) begin
							cmd.op = OP_MISS;
							state_d = S_DONE;
						end else begin
							face_d = face_q + 5'd1;
							state_d = S_BASE;
						end
					end else if (edge_q == 2'd2) begin
						lev_d = '0;
						mid_d = '0;
						state_d = (status.level == '0) ? S_DONE : S_SUM;
					end else begin
						edge_d = edge_q + 2'd1;
					end
				end
			end
			S_SUM: begin
				cmd.op = OP_SUM;
				step_d = '0;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op = OP_SQ;
				if (step_q == SQ_LAST) begin
					step_d = '0;
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.op = OP_ROOT;
				if (step_q == ROOT_LAST) begin
					step_d = '0;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (step_q == DIV_LAST) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.op = OP_WR;
				step_d = '0;
				if (mid_q == 2'd2) begin
					edge_d = '0;
					state_d = S_CTEST;
				end else begin
					mid_d = mid_q + 2'd1;
					state_d = S_SUM;
				end
			end
			S_CTEST: begin
				cmd.op = OP_PLANE;
				cmd.pair = 3'(edge_q) + PAIR_E12;
				if (step_q == PLANE_LAST) begin
					step_d = '0;
					if (status.le || edge_q == 2'd2) begin
						// last test failing means the center child
						cmd.op = OP_CHILD;
						cmd.child = status.le ? edge_q : 2'd3;
						lev_d = lev_q + 4'd1;
						mid_d = '0;
						state_d = more_levels ? S_SUM : S_DONE;
					end else begin
						edge_d = edge_q + 2'd1;
					end
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			face_q <= '0;
			edge_q <= '0;
			mid_q <= '0;
			lev_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			face_q <= face_d;
			edge_q <= edge_d;
			mid_q <= mid_d;
			lev_q <= lev_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done)) else $error("busy dropped without a result");

	a_plane_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FACE || state_q == S_CTEST) |-> step_q <= PLANE_LAST)
		else $error("plane test step out of range");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		face_q < 5'(FACES)) else $error("face counter out of range");

endmodule
